@@ rtl/core/sorted_word_list_membership_core_macros.svh @@
// ----------------------------------------------------------------------------
// sorted word list membership core: assertion macros
// clocked on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SORTED_WORD_LIST_MEMBERSHIP_CORE_MACROS_SVH
`define SORTED_WORD_LIST_MEMBERSHIP_CORE_MACROS_SVH

// plain property check
`define SWL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// implication check, antecedent and consequent in the same cycle
`define SWL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/swl_pkg.sv @@
// ----------------------------------------------------------------------------
// swl_pkg
// shared types and constants of the sorted word list membership core
// ----------------------------------------------------------------------------
package swl_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int WORD_CHARS_DEF  = 4;

    localparam int CHAR_W        = 16;
    localparam int LEN_W         = 3;
    localparam int IN_CHARS      = 4;
    localparam int KEY_LEN_LSB   = IN_CHARS * CHAR_W;
    localparam int IN_TDATA_W    = 72;
    localparam int IN_TUSER_W    = 2;
    localparam int OUT_TDATA_W   = 8;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_BAD_LEN = 2'd2
    } status_t;

    typedef enum logic [1:0]
    {
        CMP_LT,
        CMP_EQ,
        CMP_GT
    } cmp_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_COMPARE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PLACE,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        op_t              op;
        logic             sel;
        logic [LEN_W-1:0] len;
        logic             bad_len;
    } job_ctl_t;

    typedef struct packed
    {
        logic    found;
        status_t status;
    } result_t;

endpackage

@@ rtl/core/swl_ram.sv @@
// ----------------------------------------------------------------------------
// swl_ram
// one word table: single write port, single read port, registered read data
// ----------------------------------------------------------------------------
module swl_ram #(
    parameter int DEPTH = swl_pkg::TABLE_DEPTH_DEF,
    parameter int WIDTH = swl_pkg::WORD_CHARS_DEF * swl_pkg::CHAR_W
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/swl_cmp.sv @@
// ----------------------------------------------------------------------------
// swl_cmp
// orders a zero padded key against a stored entry: characters first, then length
// ----------------------------------------------------------------------------
module swl_cmp #(
    parameter int WORD_CHARS = swl_pkg::WORD_CHARS_DEF
) (
    input  logic [WORD_CHARS*swl_pkg::CHAR_W-1:0] key,
    input  logic [swl_pkg::LEN_W-1:0]             key_len,
    input  logic [WORD_CHARS*swl_pkg::CHAR_W-1:0] entry,
    output swl_pkg::cmp_t                         result
);

    localparam int CW = swl_pkg::CHAR_W;

    always_comb
    begin
        logic                       run;
        logic                       decided;
        logic [swl_pkg::LEN_W-1:0]  elen;
        swl_pkg::cmp_t              lex;
        run     = 1'b1;
        decided = 1'b0;
        elen    = '0;
        lex     = swl_pkg::CMP_EQ;
        for (int i = 0; i < WORD_CHARS; i++)
        begin
            // stored length: characters before the first zero
            if (run && entry[i*CW +: CW] != '0)
            begin
                elen = elen + 1'b1;
            end
            else
            begin
                run = 1'b0;
            end
            if (!decided && key[i*CW +: CW] != entry[i*CW +: CW])
            begin
                lex     = (key[i*CW +: CW] < entry[i*CW +: CW]) ? swl_pkg::CMP_LT
                                                                 : swl_pkg::CMP_GT;
                decided = 1'b1;
            end
        end
        priority if (lex != swl_pkg::CMP_EQ)
        begin
            result = lex;
        end
        else if (key_len < elen)
        begin
            result = swl_pkg::CMP_LT;
        end
        else if (key_len > elen)
        begin
            result = swl_pkg::CMP_GT;
        end
        else
        begin
            result = swl_pkg::CMP_EQ;
        end
    end

endmodule

@@ rtl/core/swl_ctrl.sv @@
// ----------------------------------------------------------------------------
// swl_ctrl
// sequencer: length and full checks, binary search, shift-up insert, counts
// ----------------------------------------------------------------------------
`include "sorted_word_list_membership_core_macros.svh"

module swl_ctrl #(
    parameter int TABLE_DEPTH = swl_pkg::TABLE_DEPTH_DEF,
    parameter int WORD_CHARS  = swl_pkg::WORD_CHARS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  swl_pkg::job_ctl_t                     job,
    input  logic [WORD_CHARS*swl_pkg::CHAR_W-1:0] job_key,
    output logic                                  idle,
    output logic                                  res_valid,
    output swl_pkg::result_t                      res,
    input  logic                                  out_ready,
    output logic                                  mem_sel,
    output logic                                  rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]        rd_addr,
    input  logic [WORD_CHARS*swl_pkg::CHAR_W-1:0] rd_data,
    output logic                                  wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]        wr_addr,
    output logic [WORD_CHARS*swl_pkg::CHAR_W-1:0] wr_data
);

    localparam int ENTRY_W = WORD_CHARS * swl_pkg::CHAR_W;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

    swl_pkg::state_t            state_reg, state_next;
    logic [CNT_W-1:0]           stop_count_reg, stop_count_next;
    logic [CNT_W-1:0]           measure_count_reg, measure_count_next;
    swl_pkg::op_t               op_reg, op_next;
    logic                       sel_reg, sel_next;
    logic [swl_pkg::LEN_W-1:0]  len_reg, len_next;
    logic                       bad_reg, bad_next;
    logic [ENTRY_W-1:0]         key_reg, key_next;
    logic [CNT_W-1:0]           lo_reg, lo_next;
    logic [CNT_W-1:0]           hi_reg, hi_next;
    logic [IDX_W-1:0]           mid_reg, mid_next;
    logic [IDX_W-1:0]           j_reg, j_next;
    logic                       found_reg, found_next;
    swl_pkg::status_t           status_reg, status_next;

    logic [CNT_W-1:0]           n_cur;
    logic                       is_full;
    logic                       lo_lt_hi;
    logic                       j_gt_lo;
    logic [CNT_W-1:0]           mid_full;
    logic                       is_insert;
    swl_pkg::cmp_t              cmp_res;

    swl_cmp #(
        .WORD_CHARS (WORD_CHARS)
    ) u_cmp (
        .key     (key_reg),
        .key_len (len_reg),
        .entry   (rd_data),
        .result  (cmp_res)
    );

    assign n_cur     = sel_reg ? measure_count_reg : stop_count_reg;
    assign is_full   = (n_cur >= CNT_W'(TABLE_DEPTH));
    assign lo_lt_hi  = (lo_reg < hi_reg);
    assign j_gt_lo   = (CNT_W'(j_reg) > lo_reg);
    assign mid_full  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign is_insert = (op_reg == swl_pkg::OP_INSERT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swl_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = swl_pkg::ST_CHECK;
                end
            end
            swl_pkg::ST_CHECK:
            begin
                if (is_insert && (bad_reg || is_full))
                begin
                    state_next = swl_pkg::ST_DONE;
                end
                else
                begin
                    state_next = swl_pkg::ST_SEARCH;
                end
            end
            swl_pkg::ST_SEARCH:
            begin
                priority if (lo_lt_hi)
                begin
                    state_next = swl_pkg::ST_COMPARE;
                end
                else if (!is_insert)
                begin
                    state_next = swl_pkg::ST_DONE;
                end
                else
                begin
                    state_next = swl_pkg::ST_SHIFT_RD;
                end
            end
            swl_pkg::ST_COMPARE:
            begin
                if (!is_insert && cmp_res == swl_pkg::CMP_EQ)
                begin
                    state_next = swl_pkg::ST_DONE;
                end
                else
                begin
                    state_next = swl_pkg::ST_SEARCH;
                end
            end
            swl_pkg::ST_SHIFT_RD:
            begin
                state_next = j_gt_lo ? swl_pkg::ST_SHIFT_WR : swl_pkg::ST_PLACE;
            end
            swl_pkg::ST_SHIFT_WR:
            begin
                state_next = swl_pkg::ST_SHIFT_RD;
            end
            swl_pkg::ST_PLACE:
            begin
                state_next = swl_pkg::ST_DONE;
            end
            swl_pkg::ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = swl_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // datapath
    always_comb
    begin
        stop_count_next    = stop_count_reg;
        measure_count_next = measure_count_reg;
        op_next            = op_reg;
        sel_next           = sel_reg;
        len_next           = len_reg;
        bad_next           = bad_reg;
        key_next           = key_reg;
        lo_next            = lo_reg;
        hi_next            = hi_reg;
        mid_next           = mid_reg;
        j_next             = j_reg;
        found_next         = found_reg;
        status_next        = status_reg;
        unique case (state_reg)
            swl_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = job.op;
                    sel_next    = job.sel;
                    len_next    = job.len;
                    bad_next    = job.bad_len;
                    key_next    = job_key;
                    found_next  = 1'b0;
                    status_next = swl_pkg::STATUS_OK;
                end
            end
            swl_pkg::ST_CHECK:
            begin
                lo_next = '0;
                hi_next = n_cur;
                // length check wins over the full check
                if (is_insert && bad_reg)
                begin
                    status_next = swl_pkg::STATUS_BAD_LEN;
                end
                else if (is_insert && is_full)
                begin
                    status_next = swl_pkg::STATUS_FULL;
                end
            end
            swl_pkg::ST_SEARCH:
            begin
                mid_next = mid_full[IDX_W-1:0];
                if (!lo_lt_hi && is_insert)
                begin
                    j_next = n_cur[IDX_W-1:0];
                end
            end
            swl_pkg::ST_COMPARE:
            begin
                // insert goes after equal words
                priority if (!is_insert && cmp_res == swl_pkg::CMP_EQ)
                begin
                    found_next = 1'b1;
                end
                else if (cmp_res == swl_pkg::CMP_LT)
                begin
                    hi_next = CNT_W'(mid_reg);
                end
                else
                begin
                    lo_next = CNT_W'(mid_reg) + 1'b1;
                end
            end
            swl_pkg::ST_SHIFT_RD:
            begin
            end
            swl_pkg::ST_SHIFT_WR:
            begin
                j_next = j_reg - 1'b1;
            end
            swl_pkg::ST_PLACE:
            begin
                if (sel_reg)
                begin
                    measure_count_next = measure_count_reg + 1'b1;
                end
                else
                begin
                    stop_count_next = stop_count_reg + 1'b1;
                end
            end
            swl_pkg::ST_DONE:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        idle      = (state_reg == swl_pkg::ST_IDLE);
        res_valid = (state_reg == swl_pkg::ST_DONE);
        mem_sel   = sel_reg;
        rd_en     = 1'b0;
        rd_addr   = mid_full[IDX_W-1:0];
        wr_en     = 1'b0;
        wr_addr   = lo_reg[IDX_W-1:0];
        wr_data   = key_reg;
        unique case (state_reg)
            swl_pkg::ST_SEARCH:
            begin
                rd_en = lo_lt_hi;
            end
            swl_pkg::ST_SHIFT_RD:
            begin
                rd_en   = j_gt_lo;
                rd_addr = j_reg - 1'b1;
            end
            swl_pkg::ST_SHIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = rd_data;
            end
            swl_pkg::ST_PLACE:
            begin
                wr_en = 1'b1;
            end
            swl_pkg::ST_IDLE, swl_pkg::ST_CHECK, swl_pkg::ST_COMPARE, swl_pkg::ST_DONE:
            begin
            end
        endcase
        res.found  = found_reg;
        res.status = status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= swl_pkg::ST_IDLE;
            stop_count_reg    <= '0;
            measure_count_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            stop_count_reg    <= stop_count_next;
            measure_count_reg <= measure_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        sel_reg    <= sel_next;
        len_reg    <= len_next;
        bad_reg    <= bad_next;
        key_reg    <= key_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        j_reg      <= j_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    `SWL_ASSERT_IMPL(a_compare_after_read, state_reg == swl_pkg::ST_COMPARE, $past(state_reg) == swl_pkg::ST_SEARCH, "compare without a preceding table read")
    `SWL_ASSERT_IMPL(a_compare_in_range, state_reg == swl_pkg::ST_COMPARE, lo_reg < hi_reg, "compare with an empty search window")
    `SWL_ASSERT_IMPL(a_shift_above_slot, state_reg == swl_pkg::ST_SHIFT_WR, CNT_W'(j_reg) > lo_reg, "shift write at or below the insert slot")
    `SWL_ASSERT(a_stop_count_on_place, !$stable(stop_count_reg) |-> ($past(state_reg) == swl_pkg::ST_PLACE && !$past(sel_reg)), "stop count changed outside a placement")
    `SWL_ASSERT(a_measure_count_on_place, !$stable(measure_count_reg) |-> ($past(state_reg) == swl_pkg::ST_PLACE && $past(sel_reg)), "measure count changed outside a placement")

endmodule

@@ rtl/core/sorted_word_list_membership_core.sv @@
// ----------------------------------------------------------------------------
// sorted_word_list_membership_core
// two sorted tables of short words with in-order insert and binary search lookup
//
//   channel  dir  word contents
//   s_*      in   tuser: op, list_sel / tdata: char0..char3, key_len
//   m_*      out  tdata: found, status
//
// one word at a time; a lookup makes up to k = ceil(log2(count + 1)) binary
// search probes, each a table read and then a compare; an insert searches too,
// then moves each entry above the slot up one slot with a read and a write, and
// writes the word; a refused insert goes from the check straight to the result
// reset clears the word counts but not the tables, so there is no clearing pass
// s_tready is low while a word is in work or its result waits for the output
// register; a stalled m_tready holds the result and delays the next accept
// ----------------------------------------------------------------------------
module sorted_word_list_membership_core #(
    parameter int TABLE_DEPTH = swl_pkg::TABLE_DEPTH_DEF,
    parameter int WORD_CHARS  = swl_pkg::WORD_CHARS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // op [0], list_sel [1]
    input  logic [swl_pkg::IN_TUSER_W-1:0]   s_tuser,
    // char0 [15:0], char1 [31:16], char2 [47:32], char3 [63:48], key_len [66:64]
    input  logic [swl_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // found [0], status [2:1]
    output logic [swl_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int CW      = swl_pkg::CHAR_W;
    localparam int ENTRY_W = WORD_CHARS * CW;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);

    logic                       start;
    logic                       idle;
    swl_pkg::job_ctl_t          job;
    logic [ENTRY_W-1:0]         job_key;
    logic                       res_valid;
    swl_pkg::result_t           res;
    logic                       out_ready;
    logic                       mem_sel;
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic [ENTRY_W-1:0]         rd_data;
    logic [ENTRY_W-1:0]         stop_rd_data;
    logic [ENTRY_W-1:0]         measure_rd_data;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [ENTRY_W-1:0]         wr_data;
    logic [swl_pkg::LEN_W-1:0]  key_len;

    logic                       m_valid_reg, m_valid_next;
    swl_pkg::result_t           m_res_reg;

    assign s_tready = idle;
    assign start    = s_tvalid && s_tready;
    assign key_len  = s_tdata[swl_pkg::KEY_LEN_LSB +: swl_pkg::LEN_W];

    // key preparation: drop characters past key_len, find the insert length
    always_comb
    begin
        logic [ENTRY_W-1:0]         masked;
        logic [ENTRY_W-1:0]         word;
        logic [swl_pkg::LEN_W-1:0]  elen;
        logic                       run;
        masked = '0;
        word   = '0;
        elen   = '0;
        run    = 1'b1;
        for (int i = 0; i < WORD_CHARS; i++)
        begin
            if (int'(key_len) > i)
            begin
                masked[i*CW +: CW] = s_tdata[i*CW +: CW];
            end
            if (run && masked[i*CW +: CW] != '0)
            begin
                elen               = elen + 1'b1;
                word[i*CW +: CW]   = masked[i*CW +: CW];
            end
            else
            begin
                run = 1'b0;
            end
        end
        job.op  = swl_pkg::op_t'(s_tuser[0]);
        job.sel = s_tuser[1];
        job.bad_len = (int'(key_len) > WORD_CHARS) || (elen == '0);
        if (job.op == swl_pkg::OP_LOOKUP)
        begin
            job.len = key_len;
            job_key = masked;
        end
        else
        begin
            job.len = elen;
            job_key = word;
        end
    end

    swl_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WORD_CHARS  (WORD_CHARS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .job       (job),
        .job_key   (job_key),
        .idle      (idle),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .mem_sel   (mem_sel),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    swl_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_stop_ram (
        .clk     (clk),
        .wr_en   (wr_en && !mem_sel),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en && !mem_sel),
        .rd_addr (rd_addr),
        .rd_data (stop_rd_data)
    );

    swl_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_measure_ram (
        .clk     (clk),
        .wr_en   (wr_en && mem_sel),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en && mem_sel),
        .rd_addr (rd_addr),
        .rd_data (measure_rd_data)
    );

    assign rd_data = mem_sel ? measure_rd_data : stop_rd_data;

    // output register
    assign out_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_valid && out_ready)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_ready)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(swl_pkg::OUT_TDATA_W - 3){1'b0}}, m_res_reg.status, m_res_reg.found};

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for sorted_word_list_membership_core
// streams insert and lookup words into the two word tables, predicts every
// found / status result with a behavioral copy of both sorted tables, and
// checks the results in order under several sender and receiver idle patterns
// ----------------------------------------------------------------------------
module testbench;

    localparam int       DEPTH       = swl_pkg::TABLE_DEPTH_DEF;
    localparam int       NCHARS      = swl_pkg::WORD_CHARS_DEF;
    localparam int       LONG_LEN    = 5;
    localparam logic     SEL_STOP    = 1'b0;
    localparam logic     SEL_MEASURE = 1'b1;
    localparam int       MAX_REPORTS = 20;

    typedef struct packed
    {
        logic             drain;
        logic [6:0]       src_pct;
        logic [6:0]       sink_pct;
        swl_pkg::op_t     op;
        logic             sel;
        logic [3:0][15:0] chars;
        logic [2:0]       klen;
    } word_req_t;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [swl_pkg::IN_TUSER_W-1:0]  s_tuser  = '0;
    logic [swl_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [swl_pkg::OUT_TDATA_W-1:0] m_tdata;

    // shadow of both tables and their word counts
    logic [63:0]    word_tab [2][DEPTH];
    int             word_cnt [2];

    word_req_t          pending_words [$];
    swl_pkg::result_t   expected_results [$];
    logic [63:0]        recent_words [2][$];
    word_req_t          cur_word;
    swl_pkg::result_t   want;
    logic [6:0]     sink_pct = '0;
    logic [6:0]     gen_src_pct = '0;
    logic [6:0]     gen_sink_pct = '0;
    int             sent = 0;
    int             accepted = 0;
    int             checked = 0;
    int             errors = 0;
    int             n_lookup = 0;
    int             n_hit = 0;
    int             n_stored = 0;
    int             n_full = 0;
    int             n_badlen = 0;

    sorted_word_list_membership_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic int stored_len(logic [63:0] e);
        int n;
        n = 0;
        while (n < NCHARS && e[16*n +: 16] != 16'd0)
            n++;
        return n;
    endfunction

    // -1, 0, 1 as the key sorts below, equal to or above the entry
    function automatic int word_order(logic [3:0][15:0] key, int klen, logic [63:0] e);
        int elen;
        int m;
        elen = stored_len(e);
        m = (klen < elen) ? klen : elen;
        if (m > NCHARS)
            m = NCHARS;
        for (int i = 0; i < m; i++)
        begin
            if (key[i] < e[16*i +: 16])
                return -1;
            if (key[i] > e[16*i +: 16])
                return 1;
        end
        if (klen < elen)
            return -1;
        if (klen > elen)
            return 1;
        return 0;
    endfunction

    // updates the shadow tables and returns the result the core must give
    function automatic swl_pkg::result_t table_response(word_req_t r);
        swl_pkg::result_t res;
        logic [3:0][15:0] key;
        logic [63:0]      w;
        int               klen;
        int               n;
        int               lo;
        int               hi;
        int               mid;
        int               c;
        int               elen;
        res.found  = 1'b0;
        res.status = swl_pkg::STATUS_OK;
        key  = r.chars;
        klen = r.klen;
        n    = word_cnt[r.sel];
        for (int i = 0; i < 4; i++)
            if (i >= klen || i >= NCHARS)
                key[i] = 16'd0;
        if (r.op == swl_pkg::OP_LOOKUP)
        begin
            n_lookup++;
            lo = 0;
            hi = n;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                c = word_order(key, klen, word_tab[r.sel][mid]);
                if (c == 0)
                begin
                    res.found = 1'b1;
                    break;
                end
                if (c < 0)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            if (res.found)
                n_hit++;
        end
        else
        begin
            elen = 0;
            if (klen <= NCHARS)
                while (elen < klen && key[elen] != 16'd0)
                    elen++;
            if (klen > NCHARS || elen == 0)
            begin
                res.status = swl_pkg::STATUS_BAD_LEN;
                n_badlen++;
            end
            else if (n >= DEPTH)
            begin
                res.status = swl_pkg::STATUS_FULL;
                n_full++;
            end
            else
            begin
                w = '0;
                for (int i = 0; i < elen; i++)
                    w[16*i +: 16] = key[i];
                // first slot whose entry sorts above the new word
                lo = 0;
                hi = n;
                while (lo < hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (word_order(key, elen, word_tab[r.sel][mid]) < 0)
                        hi = mid;
                    else
                        lo = mid + 1;
                end
                for (int j = n; j > lo; j--)
                    word_tab[r.sel][j] = word_tab[r.sel][j-1];
                word_tab[r.sel][lo] = w;
                word_cnt[r.sel] = n + 1;
                n_stored++;
            end
        end
        return res;
    endfunction

    // driver: one word presented at a time, changes only on the falling edge
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= sink_pct);
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && accepted != sent)
            s_tvalid <= 1'b1;
        else if (pending_words.size() == 0
                 || (pending_words[0].drain && expected_results.size() != 0)
                 || $urandom_range(0, 99) < pending_words[0].src_pct)
            s_tvalid <= 1'b0;
        else
        begin
            cur_word  = pending_words.pop_front();
            sink_pct  = cur_word.sink_pct;
            s_tvalid <= 1'b1;
            s_tuser  <= {cur_word.sel, cur_word.op};
            s_tdata  <= {5'd0, cur_word.klen, cur_word.chars};
            sent++;
        end
    end

    // monitor: check returned words first, then predict the accepted one
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t unexpected result word: found %0b status %0d",
                             $time, m_tdata[0], m_tdata[2:1]);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[0] !== want.found || m_tdata[2:1] !== want.status)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"%0t result %0d mismatch: expected found %0b status %0d,",
                                  " got found %0b status %0d"},
                                 $time, checked, want.found, want.status,
                                 m_tdata[0], m_tdata[2:1]);
                end
                checked++;
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_results.push_back(table_response(cur_word));
            accepted++;
        end
    end

    task automatic push_word(swl_pkg::op_t op, logic sel, logic [3:0][15:0] ch,
                             logic [2:0] klen, bit drain = 1'b0);
        word_req_t r;
        r.drain    = drain;
        r.src_pct  = gen_src_pct;
        r.sink_pct = gen_sink_pct;
        r.op       = op;
        r.sel      = sel;
        r.chars    = ch;
        r.klen     = klen;
        pending_words.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || expected_results.size() != 0
               || accepted != sent)
            @(posedge clk);
    endtask

    // mostly a small alphabet so that prefixes and duplicates are common
    function automatic logic [15:0] rand_char();
        case ($urandom_range(0, 7))
            0:       return 16'h0001;
            1:       return 16'h0002;
            2:       return 16'h0003;
            3:       return 16'h0041;
            4:       return 16'h7fff;
            5:       return 16'h8000;
            6:       return 16'hfffe;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    // a word already in the table, or queued for insert in this phase
    task automatic pick_word(input logic sel, output logic [63:0] e, output bit ok);
        int total;
        int idx;
        total = word_cnt[sel] + recent_words[sel].size();
        ok = (total > 0);
        e = '0;
        if (ok)
        begin
            idx = $urandom_range(0, total - 1);
            if (idx < word_cnt[sel])
                e = word_tab[sel][idx];
            else
                e = recent_words[sel][idx - word_cnt[sel]];
        end
    endtask

    task automatic gen_random(int count, bit with_drain);
        logic [3:0][15:0] ch;
        logic [63:0]      e;
        logic             sel;
        bit               ok;
        bit               drain;
        int               len;
        int               kind;
        for (int k = 0; k < count; k++)
        begin
            sel   = 1'($urandom_range(0, 1));
            drain = with_drain && ($urandom_range(0, 99) == 0);
            kind  = $urandom_range(0, 9);
            for (int i = 0; i < 4; i++)
                ch[i] = 16'($urandom);
            ok = 1'b0;
            if (kind >= 7)
                pick_word(sel, e, ok);
            if (kind < 3)
            begin
                // well-formed insert, junk past the length
                len = $urandom_range(1, NCHARS);
                for (int i = 0; i < len; i++)
                    ch[i] = rand_char();
                if (ch[0] == 16'hffff)
                    ch[0] = 16'hfffe;
                e = '0;
                for (int i = 0; i < len; i++)
                    e[16*i +: 16] = ch[i];
                recent_words[sel].push_back(e);
                push_word(swl_pkg::OP_INSERT, sel, ch, 3'(len), drain);
            end
            else if (kind < 7)
            begin
                // noise, any field value
                if ($urandom_range(0, 3) == 0)
                    ch[$urandom_range(0, 3)] = 16'd0;
                push_word(swl_pkg::op_t'($urandom_range(0, 1)), sel, ch,
                          3'($urandom_range(0, 7)), drain);
            end
            else if (!ok)
                push_word(swl_pkg::OP_LOOKUP, sel, ch, 3'($urandom_range(1, 4)), drain);
            else
            begin
                len = stored_len(e);
                for (int i = 0; i < len; i++)
                    ch[i] = e[16*i +: 16];
                if (kind < 9)
                    push_word(swl_pkg::OP_LOOKUP, sel, ch, 3'(len), drain);
                else
                begin
                    // near miss around a stored word
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            ch[len-1] = ch[len-1] ^ 16'h0001;
                            push_word(swl_pkg::OP_LOOKUP, sel, ch, 3'(len), drain);
                        end
                        1:
                        begin
                            ch[len % 4] = rand_char();
                            push_word(swl_pkg::OP_LOOKUP, sel, ch,
                                      (len < NCHARS) ? 3'(len + 1) : 3'(LONG_LEN), drain);
                        end
                        2:       push_word(swl_pkg::OP_LOOKUP, sel, ch, 3'(len - 1), drain);
                        default: push_word(swl_pkg::OP_LOOKUP, ~sel, ch, 3'(len), drain);
                    endcase
                end
            end
        end
    endtask

    task automatic run_phase(int count, int src, int sink, bit with_drain);
        gen_src_pct  = 7'(src);
        gen_sink_pct = 7'(sink);
        recent_words[0].delete();
        recent_words[1].delete();
        gen_random(count, with_drain);
        wait_idle();
    endtask

    initial
    begin
        word_cnt[0] = 0;
        word_cnt[1] = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: length errors, extremes, duplicates, prefixes, long keys
        push_word(swl_pkg::OP_LOOKUP, SEL_STOP,    {16'h0, 16'h0, 16'h0, 16'h0041}, 3'd1);
        push_word(swl_pkg::OP_INSERT, SEL_STOP,
                  {16'h1234, 16'h5678, 16'h9abc, 16'hdef0}, 3'd0);
        push_word(swl_pkg::OP_INSERT, SEL_STOP,
                  {16'h0041, 16'h0041, 16'h0041, 16'h0041}, 3'(LONG_LEN));
        push_word(swl_pkg::OP_INSERT, SEL_STOP,
                  {16'h0041, 16'h0041, 16'h0041, 16'h0041}, 3'd7);
        push_word(swl_pkg::OP_INSERT, SEL_STOP,    {16'h0, 16'h0043, 16'h0042, 16'h0}, 3'd3);
        push_word(swl_pkg::OP_INSERT, SEL_STOP,
                  {16'hffff, 16'hffff, 16'hffff, 16'h0041}, 3'd1);
        push_word(swl_pkg::OP_INSERT, SEL_STOP,    {16'h0, 16'h0, 16'h0, 16'h0041}, 3'd1);
        push_word(swl_pkg::OP_INSERT, SEL_STOP,    {16'h0008, 16'h0007, 16'h0, 16'h0005}, 3'd4);
        push_word(swl_pkg::OP_INSERT, SEL_STOP,    {16'h0, 16'h0, 16'h0042, 16'h0041}, 3'd2);
        push_word(swl_pkg::OP_INSERT, SEL_STOP,
                  {16'hffff, 16'hffff, 16'hffff, 16'hffff}, 3'd4);
        push_word(swl_pkg::OP_INSERT, SEL_MEASURE, {16'h0, 16'h0, 16'h0, 16'h0001}, 3'd1);
        push_word(swl_pkg::OP_INSERT, SEL_MEASURE,
                  {16'hffff, 16'hffff, 16'hffff, 16'hffff}, 3'd4);
        push_word(swl_pkg::OP_LOOKUP, SEL_STOP,
                  {16'h5555, 16'haaaa, 16'hffff, 16'h0041}, 3'd1);
        push_word(swl_pkg::OP_LOOKUP, SEL_STOP,    {16'h0, 16'h0, 16'h0042, 16'h0041}, 3'd2);
        push_word(swl_pkg::OP_LOOKUP, SEL_STOP,    {16'h0, 16'h0043, 16'h0042, 16'h0041}, 3'd3);
        push_word(swl_pkg::OP_LOOKUP, SEL_STOP,    {16'h0008, 16'h0007, 16'h0, 16'h0005}, 3'd4);
        push_word(swl_pkg::OP_LOOKUP, SEL_STOP,    {16'h0, 16'h0, 16'h0, 16'h0005}, 3'd1);
        push_word(swl_pkg::OP_LOOKUP, SEL_STOP,
                  {16'hffff, 16'hffff, 16'hffff, 16'hffff}, 3'(LONG_LEN));
        push_word(swl_pkg::OP_LOOKUP, SEL_STOP,
                  {16'hffff, 16'hffff, 16'hffff, 16'hffff}, 3'd4);
        push_word(swl_pkg::OP_LOOKUP, SEL_STOP,    {16'h0, 16'h0, 16'h0, 16'h0}, 3'd0);
        push_word(swl_pkg::OP_LOOKUP, SEL_STOP,
                  {16'hffff, 16'hffff, 16'hffff, 16'hffff}, 3'd6);
        push_word(swl_pkg::OP_LOOKUP, SEL_MEASURE, {16'h0, 16'h0, 16'h0, 16'h0001}, 3'd1);
        push_word(swl_pkg::OP_LOOKUP, SEL_STOP,    {16'h0, 16'h0, 16'h0, 16'h0001}, 3'd1);
        push_word(swl_pkg::OP_LOOKUP, SEL_MEASURE,
                  {16'hffff, 16'hffff, 16'hffff, 16'hffff}, 3'd4);
        wait_idle();

        run_phase(200, 0, 0, 1'b0);
        run_phase(200, 50, 0, 1'b1);
        run_phase(200, 0, 50, 1'b0);
        run_phase(200, 35, 35, 1'b1);

        // fill the stop table to the top, words sort after most random ones
        gen_src_pct  = '0;
        gen_sink_pct = '0;
        for (int k = word_cnt[0]; k < DEPTH + 3; k++)
            push_word(swl_pkg::OP_INSERT, SEL_STOP,
                      {16'h0, 16'h0, 16'(k + 1), 16'hffff}, 3'd2);
        wait_idle();

        // searches over a full stop table, inserts into it refused
        run_phase(100, 35, 35, 1'b1);

        repeat (40) @(posedge clk);
        $display("covered %0d lookups (%0d found) and %0d inserts:",
                 n_lookup, n_hit, n_stored + n_full + n_badlen);
        $display("  %0d stored, %0d full, %0d bad length; tables stop %0d, measure %0d",
                 n_stored, n_full, n_badlen, word_cnt[0], word_cnt[1]);
        if (errors == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
